### hw/rtl/ppst_pkg.sv
// ----------------------------------------------------------------------------
// ppst_pkg
// Shared types, constants and the arctangent table of the steering core.
// ----------------------------------------------------------------------------
package ppst_pkg;

	localparam int PATH_DEPTH = 1024;
	localparam int ADDR_W     = $clog2(PATH_DEPTH);
	localparam int CNT_W      = ADDR_W + 1;

	localparam int IDX_W      = 10;
	localparam int COORD_W    = 32;
	localparam int ANGLE_W    = 19;
	localparam int PLEN_W     = 11;
	localparam int LOOK_W     = 31;
	localparam int CFG_IDX_W  = 2;

	localparam int CORDIC_STEPS   = 28;
	localparam int CORDIC_W       = 34;
	localparam int TRIG_W         = 18;
	localparam int CORDIC_GAIN    = 652032874;
	localparam int PI_Q16         = 205887;
	localparam int HALF_PI_Q16    = 102944;

	localparam int LD2_W  = 2 * LOOK_W;
	localparam int LY_W   = 52;
	localparam int UY_W   = 51;
	localparam int FRAC_W = 17;
	localparam int NUM_W  = UY_W + FRAC_W;

	localparam logic [CFG_IDX_W-1:0] REG_PATH_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED       = 2'd2;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_POSE = 1'b1
	} item_kind_t;

	typedef struct packed {
		item_kind_t                 kind;
		logic [IDX_W-1:0]           idx;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic signed [ANGLE_W-1:0]  hdg;
	} item_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] turn_rate;
		logic signed [COORD_W-1:0] curvature;
		logic [IDX_W-1:0]          target;
		logic                      eop;
	} result_t;

	typedef struct packed {
		logic [PLEN_W-1:0]         path_length;
		logic [LOOK_W-1:0]         lookahead;
		logic signed [COORD_W-1:0] speed;
	} cfg_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_LD2,
		BK_SCAN1,
		BK_SCAN2,
		BK_TRIG,
		BK_MULC,
		BK_MULS,
		BK_DIVGO,
		BK_DIV,
		BK_CURV,
		BK_YAW,
		BK_OUT
	} back_state_t;

	function automatic logic signed [31:0] cordic_atan(input logic [4:0] i);
		logic signed [31:0] v;
		case (i)
			5'd0: v = 32'sd210828715;
			5'd1: v = 32'sd124459457;
			5'd2: v = 32'sd65760959;
			5'd3: v = 32'sd33381290;
			5'd4: v = 32'sd16755422;
			5'd5: v = 32'sd8385879;
			5'd6: v = 32'sd4193963;
			5'd7: v = 32'sd2097109;
			5'd8: v = 32'sd1048571;
			5'd9: v = 32'sd524287;
			default: v = 32'sd1 <<< (5'd28 - i);
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/ppst_front.sv
// ----------------------------------------------------------------------------
// ppst_front
// Take requests, tag them as load or pose, and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module ppst_front import ppst_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      cmd,
	input  logic [IDX_W-1:0]          waypoint_index,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [ANGLE_W-1:0] heading,
	output logic                      busy,
	output logic                      head_valid,
	output item_t                     head,
	input  logic                      pop
);

	item_t      slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       push;
	item_t      item;

	assign busy       = (count_q == 2'd2);
	assign push       = start && !busy;
	assign head_valid = (count_q != 2'd0);
	assign head       = slot_q[rd_q];

	always_comb begin
		item.kind = cmd ? KIND_POSE : KIND_LOAD;
		item.idx  = waypoint_index;
		item.x    = pos_x;
		item.y    = pos_y;
		item.hdg  = heading;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

### hw/rtl/ppst_cordic.sv
// ----------------------------------------------------------------------------
// ppst_cordic
// Iterative sine and cosine of the heading, one rotation step per cycle.
// ----------------------------------------------------------------------------
module ppst_cordic import ppst_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic                      busy,
	output logic signed [TRIG_W-1:0]  sin_q16,
	output logic signed [TRIG_W-1:0]  cos_q16
);

	logic signed [CORDIC_W-1:0] x_q;
	logic signed [CORDIC_W-1:0] y_q;
	logic signed [31:0]         z_q;
	logic                       neg_q;
	logic [4:0]                 step_q;
	logic                       run_q;

	logic signed [19:0]         a_ext;
	logic signed [19:0]         a_red;
	logic                       red_neg;
	logic signed [CORDIC_W-1:0] sx;
	logic signed [CORDIC_W-1:0] sy;
	logic signed [31:0]         at;
	logic signed [CORDIC_W-1:0] xn;
	logic signed [CORDIC_W-1:0] yn;
	logic signed [CORDIC_W-1:0] s_full;
	logic signed [CORDIC_W-1:0] c_full;

	assign busy = run_q;

	// fold the angle into +-pi/2, flip both results afterwards
	always_comb begin
		a_ext   = 20'(angle);
		a_red   = a_ext;
		red_neg = 1'b0;
		if (a_ext > 20'sd102944) begin
			a_red   = a_ext - 20'sd205887;
			red_neg = 1'b1;
		end else if (a_ext < -20'sd102944) begin
			a_red   = a_ext + 20'sd205887;
			red_neg = 1'b1;
		end
	end

	assign sx = x_q >>> step_q;
	assign sy = y_q >>> step_q;
	assign at = cordic_atan(step_q);

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= CORDIC_W'(CORDIC_GAIN);
			y_q   <= '0;
			z_q   <= {a_red, 12'b0};
			neg_q <= red_neg;
		end else if (run_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			step_q <= '0;
		end else if (run_q) begin
			step_q <= step_q + 5'd1;
			if (step_q == 5'(CORDIC_STEPS - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	// round Q30 to Q16
	always_comb begin
		xn      = neg_q ? -x_q : x_q;
		yn      = neg_q ? -y_q : y_q;
		s_full  = (yn + CORDIC_W'(8192)) >>> 14;
		c_full  = (xn + CORDIC_W'(8192)) >>> 14;
		sin_q16 = s_full[TRIG_W-1:0];
		cos_q16 = c_full[TRIG_W-1:0];
	end

endmodule

### hw/rtl/ppst_div.sv
// ----------------------------------------------------------------------------
// ppst_div
// Restoring divider for curvature: one quotient bit per cycle, saturation flag.
// ----------------------------------------------------------------------------
module ppst_div import ppst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [UY_W-1:0]   num,
	input  logic [LD2_W-1:0]  den,
	output logic              busy,
	output logic [31:0]       quo,
	output logic              sat
);

	logic [NUM_W-1:0]  n_q;
	logic [LD2_W-1:0]  r_q;
	logic [LD2_W-1:0]  den_q;
	logic [31:0]       q_q;
	logic              sat_q;
	logic [6:0]        cnt_q;
	logic [LD2_W:0]    r2;
	logic              ge;
	logic [LD2_W:0]    diff;

	assign busy = (cnt_q != 7'd0);
	assign quo  = q_q;
	assign sat  = sat_q;

	always_comb begin
		r2   = {r_q, n_q[NUM_W-1]};
		ge   = (r2 >= {1'b0, den_q});
		diff = r2 - {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {num, {FRAC_W{1'b0}}};
			r_q   <= '0;
			q_q   <= '0;
			den_q <= den;
			sat_q <= (den == '0) ||
				({{(LD2_W + 15 - UY_W){1'b0}}, num} >= {den, 15'b0});
		end else if (busy) begin
			n_q <= {n_q[NUM_W-2:0], 1'b0};
			r_q <= ge ? diff[LD2_W-1:0] : r2[LD2_W-1:0];
			q_q <= {q_q[30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'(NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

endmodule

### hw/rtl/ppst_back.sv
// ----------------------------------------------------------------------------
// ppst_back
// Execute queued requests: waypoint writes, the two path scans and the
// steering arithmetic of a pose.
// ----------------------------------------------------------------------------
module ppst_back import ppst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    head_valid,
	input  item_t   head,
	output logic    pop,
	output logic    result_strobe,
	output result_t result
);

	back_state_t state_q, state_d;

	logic signed [COORD_W-1:0] mem_x [PATH_DEPTH];
	logic signed [COORD_W-1:0] mem_y [PATH_DEPTH];

	logic signed [COORD_W-1:0] px_q, py_q;
	logic signed [ANGLE_W-1:0] hdg_q;
	logic [CNT_W-1:0]          n_q;
	logic [LD2_W-1:0]          ld2_q;
	logic [CNT_W-1:0]          addr_q;

	logic                      v_s1, v_s2, v_s3;
	logic [ADDR_W-1:0]         idx_s1, idx_s2, idx_s3;
	logic signed [COORD_W-1:0] rx_s1, ry_s1;
	logic signed [COORD_W:0]   dx_s2, dy_s2, dx_s3, dy_s3;
	logic [63:0]               ax2_s3, ay2_s3;

	logic                      first_q;
	logic [64:0]               best_d_q;
	logic [ADDR_W-1:0]         best_q;
	logic                      hit_q;
	logic [ADDR_W-1:0]         tgt_q;
	logic                      eop_q;
	logic signed [COORD_W:0]   tdx_q, tdy_q;

	logic signed [50:0]        p1_q;
	logic signed [LY_W-1:0]    ly_q;
	logic signed [COORD_W-1:0] curv_q;
	logic signed [ANGLE_W-1:0] yaw_q;

	logic                      issue;
	logic                      more;
	logic                      scan_done;
	logic                      mem_we;
	logic                      trig_go;
	logic                      div_go;
	logic [64:0]               d_s3;
	logic [31:0]               amx, amy;
	logic [CNT_W-1:0]          n_clamp;
	logic [UY_W-1:0]           uy;
	logic signed [50:0]        p2;
	logic signed [63:0]        prod;
	logic signed [47:0]        yaw_full;
	logic                      cor_busy, div_busy, div_sat;
	logic signed [TRIG_W-1:0]  s16, c16;
	logic [31:0]               div_q;

	ppst_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (trig_go),
		.angle   (hdg_q),
		.busy    (cor_busy),
		.sin_q16 (s16),
		.cos_q16 (c16)
	);

	ppst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (uy),
		.den    (ld2_q),
		.busy   (div_busy),
		.quo    (div_q),
		.sat    (div_sat)
	);

	always_comb begin
		if (cfg.path_length == '0) begin
			n_clamp = CNT_W'(1);
		end else if (32'(cfg.path_length) > PATH_DEPTH) begin
			n_clamp = CNT_W'(PATH_DEPTH);
		end else begin
			n_clamp = CNT_W'(cfg.path_length);
		end
	end

	assign more      = (addr_q < n_q) && !(state_q == BK_SCAN2 && hit_q);
	assign scan_done = !more && !v_s1 && !v_s2 && !v_s3;
	assign d_s3      = {1'b0, ax2_s3} + {1'b0, ay2_s3};
	assign uy        = ly_q[LY_W-1] ? UY_W'(-ly_q) : UY_W'(ly_q);
	assign p2        = 51'(s16) * 51'(tdx_q);
	assign prod      = 64'(cfg.speed) * 64'(curv_q);
	assign yaw_full  = prod[63:16];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (head_valid && head.kind == KIND_POSE) state_d = BK_LD2;
			BK_LD2:   state_d = BK_SCAN1;
			BK_SCAN1: if (scan_done) state_d = BK_SCAN2;
			BK_SCAN2: if (scan_done) state_d = BK_TRIG;
			BK_TRIG:  if (!cor_busy) state_d = BK_MULC;
			BK_MULC:  state_d = BK_MULS;
			BK_MULS:  state_d = BK_DIVGO;
			BK_DIVGO: state_d = BK_DIV;
			BK_DIV:   if (!div_busy) state_d = BK_CURV;
			BK_CURV:  state_d = BK_YAW;
			BK_YAW:   state_d = BK_OUT;
			BK_OUT:   state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop           = (state_q == BK_IDLE) && head_valid;
		mem_we        = pop && (head.kind == KIND_LOAD);
		issue         = (state_q == BK_SCAN1 || state_q == BK_SCAN2) && more;
		trig_go       = (state_q == BK_LD2);
		div_go        = (state_q == BK_DIVGO);
		result_strobe = (state_q == BK_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
		end
	end

	// waypoint store
	always_ff @(posedge clk) begin
		if (mem_we && 32'(head.idx) < PATH_DEPTH) begin
			mem_x[ADDR_W'(head.idx)] <= head.x;
			mem_y[ADDR_W'(head.idx)] <= head.y;
		end
		if (issue) begin
			rx_s1 <= mem_x[addr_q[ADDR_W-1:0]];
			ry_s1 <= mem_y[addr_q[ADDR_W-1:0]];
		end
	end

	// distance pipeline
	always_comb begin
		amx = dx_s2[COORD_W] ? 32'(-dx_s2) : 32'(dx_s2);
		amy = dy_s2[COORD_W] ? 32'(-dy_s2) : 32'(dy_s2);
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q[ADDR_W-1:0];
		dx_s2  <= 33'(rx_s1) - 33'(px_q);
		dy_s2  <= 33'(ry_s1) - 33'(py_q);
		idx_s2 <= idx_s1;
		ax2_s3 <= 64'(amx) * 64'(amx);
		ay2_s3 <= 64'(amy) * 64'(amy);
		dx_s3  <= dx_s2;
		dy_s3  <= dy_s2;
		idx_s3 <= idx_s2;
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		if (issue) begin
			addr_q <= addr_q + CNT_W'(1);
		end
		case (state_q)
			BK_IDLE: begin
				if (pop) begin
					px_q  <= head.x;
					py_q  <= head.y;
					hdg_q <= head.hdg;
					n_q   <= n_clamp;
				end
			end
			BK_LD2: begin
				ld2_q   <= LD2_W'(cfg.lookahead) * LD2_W'(cfg.lookahead);
				addr_q  <= '0;
				first_q <= 1'b1;
			end
			BK_SCAN1: begin
				if (v_s3 && (first_q || d_s3 < best_d_q)) begin
					best_d_q <= d_s3;
					best_q   <= idx_s3;
					first_q  <= 1'b0;
				end
				if (scan_done) begin
					addr_q <= {1'b0, best_q};
					hit_q  <= 1'b0;
					tgt_q  <= ADDR_W'(n_q - CNT_W'(1));
					eop_q  <= 1'b1;
				end
			end
			BK_SCAN2: begin
				if (v_s3 && !hit_q) begin
					if (d_s3 >= {3'b0, ld2_q}) begin
						hit_q <= 1'b1;
						tgt_q <= idx_s3;
						eop_q <= 1'b0;
						tdx_q <= dx_s3;
						tdy_q <= dy_s3;
					end else if ({1'b0, idx_s3} == n_q - CNT_W'(1)) begin
						tdx_q <= dx_s3;
						tdy_q <= dy_s3;
					end
				end
			end
			BK_MULC: p1_q <= 51'(c16) * 51'(tdy_q);
			BK_MULS: ly_q <= LY_W'(p1_q) - LY_W'(p2);
			BK_CURV: begin
				if (ly_q == '0) begin
					curv_q <= '0;
				end else if (ly_q[LY_W-1]) begin
					curv_q <= (div_sat || div_q > 32'h8000_0000) ?
						32'sh8000_0000 : -$signed(div_q);
				end else begin
					curv_q <= (div_sat || div_q[31]) ? 32'sh7FFF_FFFF : $signed(div_q);
				end
			end
			BK_YAW: begin
				if (yaw_full > 48'sd205887) begin
					yaw_q <= 19'sd205887;
				end else if (yaw_full < -48'sd205887) begin
					yaw_q <= -19'sd205887;
				end else begin
					yaw_q <= yaw_full[ANGLE_W-1:0];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		result.turn_rate = yaw_q;
		result.curvature = curv_q;
		result.target    = IDX_W'(tgt_q);
		result.eop       = eop_q;
	end

endmodule

### hw/rtl/pure_pursuit_steering_core.sv
// ----------------------------------------------------------------------------
// pure_pursuit_steering_core
// Pure pursuit steering: stored path, nearest and lookahead point search,
// vehicle frame rotation, curvature and clamped yaw rate.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  request   start / busy              cmd, waypoint_index, pos_x, pos_y, heading
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//  result    result_valid (strobe)     turn_rate, path_curvature, target_index,
//                                      end_of_path
//
//  A load request is written to waypoint memory while the back end is idle. A
//  pose request makes two pipelined passes over the waypoint memory (one read
//  per cycle), then runs 68 divider steps. The 28 CORDIC steps overlap the
//  scans; on very short paths the back end waits for them to finish.
//  Reset clears all control state; waypoint memory is undefined until written.
//  Results are a one-cycle strobe; the receiver cannot stall. busy rises only
//  when the two-entry request queue is full.
// ----------------------------------------------------------------------------
module pure_pursuit_steering_core import ppst_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        cmd,
	input  logic [IDX_W-1:0]            waypoint_index,
	input  logic signed [COORD_W-1:0]   pos_x,
	input  logic signed [COORD_W-1:0]   pos_y,
	input  logic signed [ANGLE_W-1:0]   heading,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [31:0]                 cfg_data,
	output logic                        result_valid,
	output logic signed [ANGLE_W-1:0]   turn_rate,
	output logic signed [COORD_W-1:0]   path_curvature,
	output logic [IDX_W-1:0]            target_index,
	output logic                        end_of_path
);

	cfg_t    cfg_q;
	logic    head_valid;
	item_t   head;
	logic    pop;
	result_t res;

	// config writes are always taken; unknown indexes drop
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.path_length <= PLEN_W'(1);
			cfg_q.lookahead   <= LOOK_W'(65536);
			cfg_q.speed       <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PATH_LENGTH: cfg_q.path_length <= cfg_data[PLEN_W-1:0];
				REG_LOOKAHEAD:   cfg_q.lookahead   <= cfg_data[LOOK_W-1:0];
				REG_SPEED:       cfg_q.speed       <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// front end: accept and queue requests
	ppst_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.cmd            (cmd),
		.waypoint_index (waypoint_index),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.heading        (heading),
		.busy           (busy),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop)
	);

	// back end: write waypoints, run the pose sequence
	ppst_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.result_strobe (result_valid),
		.result        (res)
	);

	assign turn_rate      = res.turn_rate;
	assign path_curvature = res.curvature;
	assign target_index   = res.target;
	assign end_of_path    = res.eop;

endmodule
